// ===== hw/rtl/brpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brpg_pkg
// Types and constants shared by the breathing rainbow pixel generator.
// ----------------------------------------------------------------------------
package brpg_pkg;

  // Configuration register indexes
  localparam logic REG_BRIGHTNESS_CEILING = 1'b0;
  localparam logic REG_STRIP_LENGTH       = 1'b1;

  localparam logic OP_MATRIX = 1'b0;
  localparam logic OP_STRIP  = 1'b1;

  localparam logic [7:0]  CEILING_RESET = 8'd128;
  localparam logic [15:0] STRIP_RESET   = 16'd0;

  // Breathing wave
  localparam logic [7:0] SCALE_FLOOR = 8'd100;
  localparam logic [7:0] SCALE_SLOPE = 8'd155;

  // Hue sectors are 43 hue steps wide
  localparam logic [7:0] SECTOR_SPAN = 8'd43;
  localparam logic [7:0] FULL_LEVEL  = 8'hFF;

  localparam logic [2:0] SECTOR_RED_UP     = 3'd0;
  localparam logic [2:0] SECTOR_RED_DOWN   = 3'd1;
  localparam logic [2:0] SECTOR_BLUE_UP    = 3'd2;
  localparam logic [2:0] SECTOR_GREEN_DOWN = 3'd3;
  localparam logic [2:0] SECTOR_RED_RISE   = 3'd4;

  typedef struct packed {
    logic        op;
    logic [15:0] pixel_index;
    logic [31:0] now_ms;
  } brpg_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       index_ok;
  } brpg_res_t;

endpackage

// ===== hw/rtl/breathing_rainbow_pixel_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breathing_rainbow_pixel_generator
// Per-pixel rainbow color with a triangle breathing brightness, by integer
// six-sector HSV to RGB at full saturation.
// ----------------------------------------------------------------------------
//  Channel   Ports                               Handshake
//  request   start, busy, in_req                 taken when start & !busy
//  result    out_strobe, out_res                 one-cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_data         written when cfg_we
//
//  Four register stages: hue/index check, breathing scale, level and sector,
//  then the two color products and the output register. A request is taken
//  every cycle. busy is never raised; the receiver cannot stall, so nothing
//  waits.
//  Reset (rst_n low, synchronous) clears the stage valid bits and loads the
//  brightness ceiling with 128 and the strip length with 0.
// ----------------------------------------------------------------------------
module breathing_rainbow_pixel_generator #(
  parameter int MATRIX_SIDE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  brpg_pkg::brpg_req_t in_req,
  output logic               out_strobe,
  output brpg_pkg::brpg_res_t out_res,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import brpg_pkg::*;

  localparam int YW = (MATRIX_SIDE > 1) ? $clog2(MATRIX_SIDE) : 1;
  localparam logic [16:0] MATRIX_PIXELS = 17'(MATRIX_SIDE * MATRIX_SIDE);

  logic [7:0]  ceiling_r;
  logic [15:0] strip_len_r;

  logic        accept;

  // stage 1
  logic [YW-1:0] row;
  logic [YW-1:0] col;
  logic [7:0]    idx_lo;
  logic [4:0]    diag;
  logic [7:0]    base_hue;
  logic [7:0]    strip_ofs;
  logic [8:0]    phase;
  logic          ok_nxt;
  logic [7:0]    hue_nxt;
  logic [7:0]    tri_nxt;
  logic          v1_r;
  logic          ok1_r;
  logic [7:0]    hue1_r;
  logic [7:0]    tri1_r;

  // stage 2
  logic [15:0] slope_prod;
  logic [7:0]  scale_nxt;
  logic        v2_r;
  logic        ok2_r;
  logic [7:0]  hue2_r;
  logic [7:0]  scale2_r;

  // stage 3
  logic [15:0] level_prod;
  logic [2:0]  sector_nxt;
  logic [7:0]  rem;
  logic [7:0]  frac_nxt;
  logic        v3_r;
  logic        ok3_r;
  logic [7:0]  level3_r;
  logic [2:0]  sector3_r;
  logic [7:0]  frac3_r;

  // stage 4
  logic [15:0] fall_prod;
  logic [15:0] rise_prod;
  logic [7:0]  fall;
  logic [7:0]  rise;
  brpg_res_t   res_nxt;
  logic        out_strobe_r;
  brpg_res_t   out_res_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r   <= CEILING_RESET;
      strip_len_r <= STRIP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRIGHTNESS_CEILING: ceiling_r   <= cfg_data[7:0];
        REG_STRIP_LENGTH:       strip_len_r <= cfg_data;
        default:                ;
      endcase
    end
  end

  // Stage 1: index check, hue and triangle phase
  assign idx_lo = in_req.pixel_index[7:0];

  always_comb begin
    row = '0;
    for (int r = 1; r < MATRIX_SIDE; r++) begin
      if (idx_lo >= 8'(r * MATRIX_SIDE)) begin
        row = YW'(row + 1'b1);
      end
    end
  end

  assign col       = YW'(idx_lo - 8'(32'(row) * MATRIX_SIDE));
  assign diag      = 5'(col) + 5'(row);
  assign base_hue  = in_req.now_ms[11:4];
  // index * 24 wrapped to 8 bits
  assign strip_ofs = {5'(idx_lo[4:0] * 5'd3), 3'b000};
  assign phase     = in_req.now_ms[11:3];

  always_comb begin
    if (in_req.op == OP_MATRIX) begin
      ok_nxt  = ({1'b0, in_req.pixel_index} < MATRIX_PIXELS);
      hue_nxt = base_hue + {diag[3:0], 4'b0000};
    end else begin
      ok_nxt  = (in_req.pixel_index < strip_len_r);
      hue_nxt = base_hue + strip_ofs;
    end
    // fold the upper half of the phase back down
    tri_nxt = phase[8] ? ~phase[7:0] : phase[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ok1_r  <= ok_nxt;
    hue1_r <= hue_nxt;
    tri1_r <= tri_nxt;
  end

  // Stage 2: breathing scale
  assign slope_prod = tri1_r * SCALE_SLOPE;
  assign scale_nxt  = SCALE_FLOOR + slope_prod[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ok2_r    <= ok1_r;
    hue2_r   <= hue1_r;
    scale2_r <= scale_nxt;
  end

  // Stage 3: level, sector and fraction
  assign level_prod = ceiling_r * scale2_r;

  always_comb begin
    sector_nxt = '0;
    for (int s = 1; s < 6; s++) begin
      if (hue2_r >= 8'(s * SECTOR_SPAN)) begin
        sector_nxt = 3'(s);
      end
    end
    rem      = hue2_r - 8'(sector_nxt * SECTOR_SPAN);
    frac_nxt = 8'(rem * 8'd6);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ok3_r     <= ok2_r;
    level3_r  <= level_prod[15:8];
    sector3_r <= sector_nxt;
    frac3_r   <= frac_nxt;
  end

  // Stage 4: ramps and sector select
  assign fall_prod = level3_r * (FULL_LEVEL - frac3_r);
  assign rise_prod = level3_r * frac3_r;
  assign fall      = fall_prod[15:8];
  assign rise      = rise_prod[15:8];

  always_comb begin
    res_nxt = '0;
    unique case (sector3_r)
      SECTOR_RED_UP: begin
        res_nxt.red   = level3_r;
        res_nxt.green = rise;
      end
      SECTOR_RED_DOWN: begin
        res_nxt.red   = fall;
        res_nxt.green = level3_r;
      end
      SECTOR_BLUE_UP: begin
        res_nxt.green = level3_r;
        res_nxt.blue  = rise;
      end
      SECTOR_GREEN_DOWN: begin
        res_nxt.green = fall;
        res_nxt.blue  = level3_r;
      end
      SECTOR_RED_RISE: begin
        res_nxt.red  = rise;
        res_nxt.blue = level3_r;
      end
      default: begin
        res_nxt.red  = level3_r;
        res_nxt.blue = fall;
      end
    endcase
    // drop the color for an index outside the target
    if (!ok3_r) begin
      res_nxt = '0;
    end else begin
      res_nxt.index_ok = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule
